// ===== rtl/hbia_pkg.sv =====
// Shared types, constants and tree-geometry functions of the bitmap index allocator.
`timescale 1ns / 1ps

package hbia_pkg;

   localparam int IDX_W       = 10;
   localparam int SIZE_W      = 11;
   localparam int ACT_W       = 2;
   localparam int MAX_INDICES = 1024;
   localparam int MAX_LEVELS  = 4;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int LEVELS_DEFAULT    = 2;

   localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = SIZE_W'(MAX_INDICES);

   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_DESC,
      ST_ASC
   } state_type;

   // indices covered by one bit of a word at level l (level 0 is the root)
   function automatic int span_of(input int wb, input int levels, input int l);
      int s;
      s = 1;
      for (int k = l + 1; k < levels; k++) begin
         s = s * wb;
      end
      return s;
   endfunction

   function automatic int cap_of(input int wb, input int levels);
      int c;
      c = span_of(wb, levels, 0) * wb;
      if (c > MAX_INDICES) begin
         c = MAX_INDICES;
      end
      return c;
   endfunction

   function automatic int words_of(input int wb, input int levels, input int l);
      int per;
      int cnt;
      per = wb * span_of(wb, levels, l);
      cnt = 0;
      for (int i = 0; i < MAX_INDICES; i++) begin
         if (i * per < cap_of(wb, levels)) begin
            cnt = cnt + 1;
         end
      end
      return cnt;
   endfunction

   function automatic int offset_of(input int wb, input int levels, input int l);
      int o;
      o = 0;
      for (int j = 0; j < l; j++) begin
         o = o + words_of(wb, levels, j);
      end
      return o;
   endfunction

   function automatic int thr_of(input int wb, input int levels, input int l, input int k);
      return k * span_of(wb, levels, l);
   endfunction

endpackage

// ===== rtl/hbia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 33,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hierarchical_bitmap_index_allocator_unit.sv =====
// Top level of the hierarchical bitmap index allocator: sequencer, tree RAM and result register.
`timescale 1ns / 1ps

// Indices are kept free/used in a tree of bitmap words held in one RAM, one word read or
// written per cycle. An item is taken when start is high and busy low. Allocate, free and
// query walk down the tree one level a cycle, then allocate and free write back upward one
// level a cycle until a word needs no further change or the root is written. Out-of-range
// free or query, an unknown action and allocate on an empty pool finish in the cycle they
// are taken. The result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in the cycle after the item finishes; it cannot be held off, and a new item
// may be taken while it shows. After reset and after every csr_we the tree is rebuilt by
// a pass that writes one RAM word a cycle, over every word of all levels, with busy high.
module hierarchical_bitmap_index_allocator_unit #(
   parameter int WORD_BITS = hbia_pkg::WORD_BITS_DEFAULT,
   parameter int LEVELS    = hbia_pkg::LEVELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hbia_pkg::ACT_W-1:0]    req_action,
   input  logic [hbia_pkg::IDX_W-1:0]    req_index,
   output logic                          rsp_valid,
   output logic                          rsp_granted,
   output logic [hbia_pkg::IDX_W-1:0]    rsp_result_index,
   output logic                          rsp_is_used,
   output logic                          rsp_any_free,
   input  logic                          csr_we,
   input  logic [hbia_pkg::SIZE_W-1:0]   csr_wdata
);

   localparam int IDX_W     = hbia_pkg::IDX_W;
   localparam int SIZE_W    = hbia_pkg::SIZE_W;
   localparam int ACT_W     = hbia_pkg::ACT_W;
   localparam int CAP       = hbia_pkg::cap_of(WORD_BITS, LEVELS);
   localparam int RAM_DEPTH = hbia_pkg::offset_of(WORD_BITS, LEVELS, LEVELS);
   localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DW        = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   function automatic logic [AW-1:0] level_base(input logic [LVL_W-1:0] l);
      logic [AW-1:0] r;
      r = '0;
      for (int j = 0; j < LEVELS; j++) begin
         if (l == LVL_W'(j)) begin
            r = AW'(hbia_pkg::offset_of(WORD_BITS, LEVELS, j));
         end
      end
      return r;
   endfunction

   hbia_pkg::state_type state_ff, state_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [AW-1:0]       widx_ff, widx_in;
   logic [SIZE_W-1:0]   base_ff, base_in;
   logic [SIZE_W-1:0]   pool_ff, pool_in;
   logic                root_ff, root_in;
   logic [ACT_W-1:0]    act_ff, act_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   word_type            word_ff [LEVELS];
   word_type            word_in [LEVELS];
   logic [DW-1:0]       digit_ff [LEVELS];
   logic [DW-1:0]       digit_in [LEVELS];
   logic [IDX_W-1:0]    path_ff [LEVELS];
   logic [IDX_W-1:0]    path_in [LEVELS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                rsp_used_ff, rsp_used_in;
   logic                rsp_free_ff, rsp_free_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   word_type            ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   word_type            ram_rd_data;

   logic [SIZE_W-1:0]   n_eff;
   logic [SIZE_W-1:0]   sweep_rem;
   word_type            sweep_word;
   logic [AW-1:0]       widx_last;
   logic [SIZE_W-1:0]   base_step;

   logic [DW-1:0]       alloc_digit;
   logic [DW-1:0]       rem_digit;
   logic [IDX_W-1:0]    rem_sub;
   logic [DW-1:0]       digit;
   logic [IDX_W-1:0]    pos_next;

   hbia_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (RAM_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign n_eff = (pool_ff > SIZE_W'(CAP)) ? SIZE_W'(CAP) : pool_ff;

   // rebuild word: bit set when its subtree holds an index below the pool size
   always_comb begin
      sweep_rem  = (n_eff > base_ff) ? (n_eff - base_ff) : '0;
      sweep_word = '0;
      widx_last  = '0;
      base_step  = '0;
      for (int j = 0; j < LEVELS; j++) begin
         if (lvl_ff == LVL_W'(j)) begin
            widx_last = AW'(hbia_pkg::words_of(WORD_BITS, LEVELS, j) - 1);
            base_step = SIZE_W'(WORD_BITS * hbia_pkg::span_of(WORD_BITS, LEVELS, j));
            for (int b = 0; b < WORD_BITS; b++) begin
               sweep_word[b] = 32'(sweep_rem) > 32'(hbia_pkg::thr_of(WORD_BITS, LEVELS, j, b));
            end
         end
      end
   end

   // digit at the current level: lowest free bit, or digit of the requested index
   always_comb begin
      alloc_digit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (ram_rd_data[b]) begin
            alloc_digit = DW'(b);
         end
      end
      rem_digit = '0;
      rem_sub   = '0;
      for (int j = 0; j < LEVELS; j++) begin
         if (lvl_ff == LVL_W'(j)) begin
            for (int k = 1; k < WORD_BITS; k++) begin
               if (32'(rem_ff) >= 32'(hbia_pkg::thr_of(WORD_BITS, LEVELS, j, k))) begin
                  rem_digit = DW'(k);
                  rem_sub   = IDX_W'(hbia_pkg::thr_of(WORD_BITS, LEVELS, j, k));
               end
            end
         end
      end
      digit    = (act_ff == hbia_pkg::ACT_ALLOC) ? alloc_digit : rem_digit;
      pos_next = IDX_W'(pos_ff * WORD_BITS) + IDX_W'(digit);
   end

   always_comb begin
      logic               fin;
      logic               fin_granted;
      logic [IDX_W-1:0]   fin_index;
      logic               fin_used;
      logic               fin_free;
      word_type           w;
      word_type           m;
      word_type           nw;
      logic               stop;

      state_in    = state_ff;
      lvl_in      = lvl_ff;
      widx_in     = widx_ff;
      base_in     = base_ff;
      pool_in     = pool_ff;
      root_in     = root_ff;
      act_in      = act_ff;
      rem_in      = rem_ff;
      pos_in      = pos_ff;
      word_in     = word_ff;
      digit_in    = digit_ff;
      path_in     = path_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_addr = level_base('0);
      fin         = 1'b0;
      fin_granted = 1'b0;
      fin_index   = '0;
      fin_used    = 1'b0;
      fin_free    = root_ff;
      w           = word_ff[lvl_ff];
      m           = word_type'(1) << digit_ff[lvl_ff];
      nw          = '0;
      stop        = 1'b0;

      case (state_ff)
         hbia_pkg::ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = level_base(lvl_ff) + widx_ff;
            ram_wr_data = sweep_word;
            if (lvl_ff == '0) begin
               root_in = |sweep_word;
            end
            if (widx_ff == widx_last) begin
               widx_in = '0;
               base_in = '0;
               if (lvl_ff == LVL_W'(LEVELS - 1)) begin
                  lvl_in   = '0;
                  state_in = hbia_pkg::ST_IDLE;
               end else begin
                  lvl_in = LVL_W'(lvl_ff + 1'b1);
               end
            end else begin
               widx_in = widx_ff + 1'b1;
               base_in = base_ff + base_step;
            end
         end
         hbia_pkg::ST_IDLE: begin
            if (start) begin
               act_in = req_action;
               rem_in = req_index;
               pos_in = '0;
               lvl_in = '0;
               case (req_action)
                  hbia_pkg::ACT_ALLOC: begin
                     if (root_ff) begin
                        state_in = hbia_pkg::ST_DESC;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  hbia_pkg::ACT_FREE, hbia_pkg::ACT_QUERY: begin
                     if ({1'b0, req_index} < n_eff) begin
                        state_in = hbia_pkg::ST_DESC;
                     end else begin
                        fin      = 1'b1;
                        fin_used = (req_action == hbia_pkg::ACT_QUERY);
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         hbia_pkg::ST_DESC: begin
            word_in[lvl_ff]  = ram_rd_data;
            digit_in[lvl_ff] = digit;
            path_in[lvl_ff]  = pos_ff;
            rem_in           = rem_ff - rem_sub;
            pos_in           = pos_next;
            if (act_ff == hbia_pkg::ACT_ALLOC && ram_rd_data == '0) begin
               fin      = 1'b1;
               state_in = hbia_pkg::ST_IDLE;
            end else if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               case (act_ff)
                  hbia_pkg::ACT_ALLOC: begin
                     if ({1'b0, pos_next} < n_eff) begin
                        state_in = hbia_pkg::ST_ASC;
                     end else begin
                        fin      = 1'b1;
                        state_in = hbia_pkg::ST_IDLE;
                     end
                  end
                  hbia_pkg::ACT_QUERY: begin
                     fin      = 1'b1;
                     fin_used = ~ram_rd_data[digit];
                     state_in = hbia_pkg::ST_IDLE;
                  end
                  default: begin
                     state_in = hbia_pkg::ST_ASC;
                  end
               endcase
            end else begin
               lvl_in      = LVL_W'(lvl_ff + 1'b1);
               ram_rd_addr = level_base(LVL_W'(lvl_ff + 1'b1)) + AW'(pos_next);
            end
         end
         hbia_pkg::ST_ASC: begin
            if (act_ff == hbia_pkg::ACT_FREE) begin
               nw   = w | m;
               stop = |w;
            end else begin
               nw   = w & ~m;
               stop = |nw;
            end
            ram_wr_en   = 1'b1;
            ram_wr_addr = level_base(lvl_ff) + AW'(path_ff[lvl_ff]);
            ram_wr_data = nw;
            if (lvl_ff == '0) begin
               root_in  = |nw;
               fin_free = |nw;
            end
            if (stop || lvl_ff == '0) begin
               fin         = 1'b1;
               fin_granted = (act_ff == hbia_pkg::ACT_ALLOC);
               fin_index   = (act_ff == hbia_pkg::ACT_ALLOC) ? pos_ff : '0;
               lvl_in      = '0;
               state_in    = hbia_pkg::ST_IDLE;
            end else begin
               lvl_in = LVL_W'(lvl_ff - 1'b1);
            end
         end
         default: begin
            state_in = hbia_pkg::ST_IDLE;
         end
      endcase

      if (csr_we) begin
         pool_in  = csr_wdata;
         lvl_in   = '0;
         widx_in  = '0;
         base_in  = '0;
         state_in = hbia_pkg::ST_INIT;
      end

      rsp_valid_in   = fin;
      rsp_granted_in = fin ? fin_granted : rsp_granted_ff;
      rsp_index_in   = fin ? fin_index : rsp_index_ff;
      rsp_used_in    = fin ? fin_used : rsp_used_ff;
      rsp_free_in    = fin ? fin_free : rsp_free_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbia_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff       <= '0;
         widx_ff      <= '0;
         base_ff      <= '0;
         pool_ff      <= hbia_pkg::POOL_SIZE_RESET;
         root_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lvl_ff       <= lvl_in;
         widx_ff      <= widx_in;
         base_ff      <= base_in;
         pool_ff      <= pool_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      rem_ff         <= rem_in;
      pos_ff         <= pos_in;
      word_ff        <= word_in;
      digit_ff       <= digit_in;
      path_ff        <= path_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign busy             = (state_ff != hbia_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_is_used      = rsp_used_ff;
   assign rsp_any_free     = rsp_free_ff;

`ifndef ASSERT_OFF
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither in progress nor answered");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> {1'b0, ram_wr_addr} < (AW + 1)'(RAM_DEPTH))
      else $error("tree write outside RAM");

   a_grant_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> !rsp_is_used && ({1'b0, rsp_result_index} < n_eff))
      else $error("granted index outside pool");
`endif

endmodule
